@@ rtl/fcsg_pkg.sv @@
package fcsg_pkg;

  // defaults for the top level parameters
  localparam int unsigned MaxRadiusDef = 63;
  localparam int unsigned CoordBitsDef = 12;

  // fixed field widths
  localparam int unsigned RadBits = 6;   // radius field
  localparam int unsigned OfsBits = 8;   // signed walk offsets, down may reach -1
  localparam int unsigned DecBits = 9;   // signed decision value
  localparam int unsigned CalcBits = 10; // headroom for the update arithmetic

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // take a new circle from the input beat
    logic step;  // emit one span group and advance the walk
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
    logic last_step;  // the step now on offer ends the walk
  } sts_t;

endpackage

@@ rtl/fcsg_ctrl.sv @@
module fcsg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fcsg_pkg::sts_t sts_i,
  output fcsg_pkg::cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.last_step) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/fcsg_datapath.sv @@
module fcsg_datapath #(
  parameter int unsigned MAX_RADIUS = fcsg_pkg::MaxRadiusDef,
  parameter int unsigned COORD_BITS = fcsg_pkg::CoordBitsDef,
  localparam int unsigned InW  = ((2 * COORD_BITS + fcsg_pkg::RadBits + 7) / 8) * 8,
  localparam int unsigned OutB = COORD_BITS + 1,
  localparam int unsigned OutW = ((8 * OutB + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [InW-1:0]  in_data_i,
  input  fcsg_pkg::cmd_t  cmd_i,
  output fcsg_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [OutW-1:0] out_data_o,
  output logic            out_last_o
);

  localparam int unsigned OB = fcsg_pkg::OfsBits;
  localparam int unsigned DB = fcsg_pkg::DecBits;
  localparam int unsigned CB = fcsg_pkg::CalcBits;
  localparam int unsigned RB = fcsg_pkg::RadBits;
  localparam logic [RB-1:0] RadMax = RB'(MAX_RADIUS);

  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic [RB-1:0]                rad_q;
  logic signed [OB-1:0]         across_q, down_q, across_d, down_d;
  logic signed [DB-1:0]         dec_q;
  logic signed [CB-1:0]         dec_d;
  logic                         out_valid_q;
  logic [OutW-1:0]              out_data_q;
  logic                         out_last_q;

  logic [RB-1:0]        in_rad, rad_sat;
  logic signed [CB-1:0] a_w, dn_w, d_w, r_w;
  logic [8*OutB-1:0]    spans;

  assign in_rad  = in_data_i[2*COORD_BITS +: RB];
  assign rad_sat = (in_rad > RadMax) ? RadMax : in_rad;

  // one walk update, three moves picked by the decision value
  always_comb begin
    a_w  = CB'(across_q);
    dn_w = CB'(down_q);
    d_w  = CB'(dec_q);
    r_w  = $signed(CB'(rad_q));
    if (d_w >= (a_w <<< 1)) begin
      dec_d    = d_w - (a_w <<< 1) - CB'(1);
      across_d = across_q + OB'(1);
      down_d   = down_q;
    end else if (d_w < ((r_w - dn_w) <<< 1)) begin
      dec_d    = d_w + (dn_w <<< 1) - CB'(1);
      across_d = across_q;
      down_d   = down_q - OB'(1);
    end else begin
      dec_d    = d_w + ((dn_w - a_w - CB'(1)) <<< 1);
      across_d = across_q + OB'(1);
      down_d   = down_q - OB'(1);
    end
  end

  function automatic logic [OutB-1:0] add_ofs(input logic signed [COORD_BITS-1:0] c,
                                               input logic signed [OB-1:0] o,
                                               input logic neg);
    logic signed [OutB-1:0] ce, oe;
    ce = OutB'(c);
    oe = OutB'(o);
    return neg ? (ce - oe) : (ce + oe);
  endfunction

  assign spans = {add_ofs(cy_q, down_q, 1'b1),   add_ofs(cy_q, down_q, 1'b0),
                  add_ofs(cx_q, across_q, 1'b0), add_ofs(cx_q, across_q, 1'b1),
                  add_ofs(cy_q, across_q, 1'b1), add_ofs(cy_q, across_q, 1'b0),
                  add_ofs(cx_q, down_q, 1'b0),   add_ofs(cx_q, down_q, 1'b1)};

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.last_step = !(down_d >= across_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q     <= in_data_i[COORD_BITS-1:0];
      cy_q     <= in_data_i[COORD_BITS +: COORD_BITS];
      rad_q    <= rad_sat;
      across_q <= '0;
      down_q   <= OB'(rad_sat);
      dec_q    <= DB'(rad_sat) - DB'(1);
    end else if (cmd_i.step) begin
      across_q <= across_d;
      down_q   <= down_d;
      dec_q    <= DB'(dec_d);
    end
    if (cmd_i.step) begin
      out_data_q <= OutW'(spans);
      out_last_q <= sts_o.last_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

@@ rtl/filled_circle_span_generator_unit.sv @@
// first span group: the circle beat loads the walk registers, then a step fills the output register
// throughput: one span group per cycle while the receiver is ready; the walk register
//   update is the single loop that sets it
// a new circle beat is taken once the previous walk has issued its last group
// reset: rst_ni is asynchronous, active low; clears controller and output valid
module filled_circle_span_generator_unit #(
  parameter int unsigned MAX_RADIUS = fcsg_pkg::MaxRadiusDef,
  parameter int unsigned COORD_BITS = fcsg_pkg::CoordBitsDef,
  localparam int unsigned InW  = ((2 * COORD_BITS + fcsg_pkg::RadBits + 7) / 8) * 8,
  localparam int unsigned OutW = ((8 * (COORD_BITS + 1) + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // circle beat in
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [InW-1:0]  s_axis_tdata_i,   // center_x, center_y, radius, zero pad
  // span group beat out
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o,   // outer_left, outer_right, outer_row_below,
                                            // outer_row_above, inner_left, inner_right,
                                            // inner_row_below, inner_row_above
  output logic            m_axis_tlast_o    // last_of_circle
);

  fcsg_pkg::cmd_t cmd;
  fcsg_pkg::sts_t sts;

  // controller: idle / walking, issues load and step commands
  fcsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: walk registers, span adders and the output register
  fcsg_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

@@ sim/tb_filled_circle_span_generator_unit.sv @@
module tb_filled_circle_span_generator_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordBits = fcsg_pkg::CoordBitsDef;
  localparam int unsigned InW       = ((2 * CoordBits + fcsg_pkg::RadBits + 7) / 8) * 8;
  localparam int unsigned OutW      = ((8 * (CoordBits + 1) + 7) / 8) * 8;
  localparam int          MaxGroups = 64;      // hard cap on span groups per circle
  localparam int          RandCircles = 150;
  localparam int          CycleLimit  = 600000;
  localparam int          HoldAfter   = 40;    // circles accepted before the long stall
  localparam int          HoldCycles  = 500;
  localparam int          TailCycles  = 20;

  // one circle as it sits in the stimulus queue
  typedef struct packed {
    logic                 drain_first;  // sender waits for all spans before offering it
    logic [5:0]           rad;
    logic [CoordBits-1:0] cy;
    logic [CoordBits-1:0] cx;
  } circle_t;

  // one span group beat, coordinates from the lowest tdata bits up
  typedef struct packed {
    logic                    last;
    logic [7:0][CoordBits:0] coord;
  } span_group_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [InW-1:0]  s_axis_tdata_i = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  logic [OutW-1:0] m_axis_tdata_o;
  logic            m_axis_tlast_o;

  circle_t     circle_q [$];   // circles not yet offered
  span_group_t span_q [$];     // span groups predicted, oldest first
  circle_t     offered_circle;
  span_group_t got_group;
  span_group_t want_group;

  int   mismatch_count = 0;
  int   accepted_circles = 0;
  int   cycle_count = 0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic [15:0] stall_pat = 16'hffff;
  int   pat_age = 0;
  logic offering;

  string span_field_name [8] = '{"outer_left", "outer_right", "outer_row_below",
                                 "outer_row_above", "inner_left", "inner_right",
                                 "inner_row_below", "inner_row_above"};

  filled_circle_span_generator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // walk the circle and queue every span group it gives
  function automatic void predict_circle_spans(circle_t c);
    int          cx;
    int          cy;
    int          rad;
    int          across;
    int          down;
    int          dec;
    int          groups;
    span_group_t g;
    cx  = $signed(c.cx);
    cy  = $signed(c.cy);
    rad = c.rad;
    if (rad > int'(fcsg_pkg::MaxRadiusDef)) begin
      rad = fcsg_pkg::MaxRadiusDef;
    end
    across = 0;
    down   = rad;
    dec    = rad - 1;
    groups = 0;
    while (down >= across && groups < MaxGroups) begin
      g.coord[0] = 13'(cx - down);
      g.coord[1] = 13'(cx + down);
      g.coord[2] = 13'(cy + across);
      g.coord[3] = 13'(cy - across);
      g.coord[4] = 13'(cx - across);
      g.coord[5] = 13'(cx + across);
      g.coord[6] = 13'(cy + down);
      g.coord[7] = 13'(cy - down);
      // three moves: across, down, or diagonal
      if (dec >= 2 * across) begin
        dec    = dec - (2 * across + 1);
        across = across + 1;
      end else if (dec < 2 * (rad - down)) begin
        dec  = dec + 2 * down - 1;
        down = down - 1;
      end else begin
        dec    = dec + 2 * (down - across - 1);
        down   = down - 1;
        across = across + 1;
      end
      groups = groups + 1;
      g.last = (down < across) || (groups >= MaxGroups);
      span_q.push_back(g);
    end
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    mismatch_count = mismatch_count + 1;
    if (mismatch_count <= 10) begin
      $display("mismatch %0s: expected %0d, got %0d", field, want, got);
    end
  endtask

  task automatic add_circle(int cx, int cy, int rad, logic drain);
    circle_t c;
    c.cx          = cx[CoordBits-1:0];
    c.cy          = cy[CoordBits-1:0];
    c.rad         = rad[5:0];
    c.drain_first = drain;
    circle_q.push_back(c);
  endtask

  // circle driver: bursts of beats with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      offering = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_circle_spans(offered_circle);
        accepted_circles <= accepted_circles + 1;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else if (circle_q.size() != 0 &&
                     (!circle_q[0].drain_first || span_q.size() == 0)) begin
          offered_circle = circle_q.pop_front();
          s_axis_tdata_i <= {2'b00, offered_circle.rad, offered_circle.cy, offered_circle.cx};
          offering = 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 10);
            // some bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      s_axis_tvalid_i <= offering;
    end
  end

  // one long receiver stall once the stream is going, sender keeps offering
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_circles >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // span group monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_pat = 16'hffff;
      pat_age   = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_group.coord = m_axis_tdata_o[8*(CoordBits+1)-1:0];
        got_group.last  = m_axis_tlast_o;
        if (span_q.size() == 0) begin
          report_mismatch("unexpected beat, tlast", -1, got_group.last);
        end else begin
          want_group = span_q.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got_group.coord[i] !== want_group.coord[i]) begin
              report_mismatch(span_field_name[i], $signed(want_group.coord[i]),
                              $signed(got_group.coord[i]));
            end
          end
          if (got_group.last !== want_group.last) begin
            report_mismatch("last_of_circle", want_group.last, got_group.last);
          end
        end
      end
      // new pattern each time pat_age wraps: sometimes never stalling, never fully blocked
      pat_age = pat_age + 1;
      if (pat_age >= 64) begin
        pat_age   = 0;
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      end else begin
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      m_axis_tready_i <= (hold_left == 0) && stall_pat[0];
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    // zero radius collapses to the center, one group marked last
    add_circle(0, 0, 0, 1'b0);
    add_circle(-2048, 2047, 0, 1'b0);
    add_circle(2047, -2048, 0, 1'b0);
    // tiny radii exercise every move of the walk
    add_circle(0, 0, 1, 1'b0);
    add_circle(0, 0, 2, 1'b0);
    add_circle(0, 0, 3, 1'b0);
    add_circle(-1, -1, 4, 1'b0);
    // largest radius at the center and at every corner of the coordinate range, spans run past it
    add_circle(0, 0, 63, 1'b0);
    add_circle(2047, 2047, 63, 1'b0);
    add_circle(-2048, -2048, 63, 1'b0);
    add_circle(2047, -2048, 63, 1'b0);
    add_circle(-2048, 2047, 63, 1'b0);
    // alternating bit patterns in every field
    add_circle(12'h555, 12'haaa, 6'h2a, 1'b0);
    add_circle(12'haaa, 12'h555, 6'h15, 1'b0);
    add_circle(5, -7, 32, 1'b0);
    add_circle(-300, 400, 31, 1'b0);
    add_circle(-2048, 0, 5, 1'b0);
    add_circle(2047, 0, 10, 1'b0);
    add_circle(0, 2047, 17, 1'b0);
    add_circle(0, -2048, 50, 1'b0);
    // sender waits for the directed spans to drain
    add_circle(100, -100, 9, 1'b1);
    for (int n = 0; n < RandCircles; n++) begin
      add_circle($urandom, $urandom,
                 ($urandom_range(0, 9) < 4) ? $urandom_range(0, 7) : $urandom_range(0, 63),
                 (n % 40) == 39);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (circle_q.size() != 0 || s_axis_tvalid_i) begin
      @(posedge clk_i);
    end
    while (span_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (span_q.size() != 0) begin
      report_mismatch("span groups still owed", 0, span_q.size());
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fcsg_pkg.sv
rtl/fcsg_ctrl.sv
rtl/fcsg_datapath.sv
rtl/filled_circle_span_generator_unit.sv
sim/tb_filled_circle_span_generator_unit.sv
